// ===== rtl/ibgc_pkg.sv =====
// ibgc_pkg: shared types and constants for the IMU bias/gain calibrator.
// No dependencies; imported by every module under rtl/.
package ibgc_pkg;

  localparam int unsigned DivW   = 26;  // signed dividend width of a mean-update lane
  localparam int unsigned DvsW   = 16;  // divisor width (sample index + 1)
  localparam int unsigned RadW   = 50;  // sum of squared accel residuals
  localparam int unsigned RootW  = 25;
  localparam int unsigned RecipW = 39;  // 2^(35 + select) needs 39 bits
  localparam int unsigned GainW  = 18;

  localparam logic [14:0] WarmupSamples = 15'd10;
  localparam logic [6:0]  MaxRestarts   = 7'd100;
  localparam logic [6:0]  RestartSat    = 7'd127;
  localparam logic [GainW-1:0] GainOne  = 18'd65536;
  localparam logic [GainW-1:0] GainMax  = 18'd262143;
  localparam logic signed [23:0] B24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] B24Min = 24'sh800000;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_DONE    = 2'd1,
    ST_FAILED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_ACCEL_RANGE  = 2'd1,
    CFG_STILL_THR    = 2'd2
  } cfg_idx_e;

  // Result of one mean-update lane.
  typedef struct packed {
    logic                   done;
    logic signed [DivW-1:0] quotient;
  } div_res_t;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'(B24Max)) r = B24Max;
    else if (v < 27'(B24Min)) r = B24Min;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ===== rtl/ibgc_div_lane.sv =====
// ibgc_div_lane: signed / unsigned restoring divider, truncates toward zero.
// One quotient bit per cycle. Depends on ibgc_pkg.
module ibgc_div_lane import ibgc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0]        divisor_i,
  output div_res_t               res_o
);

  localparam logic [4:0] LastStep = 5'(DivW - 1);

  logic            busy_q, done_q, neg_q;
  logic [4:0]      cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   rem_sh, rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= dividend_i[DivW-1];
      quo_q  <= dividend_i[DivW-1] ? DivW'(-dividend_i) : DivW'(dividend_i);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/ibgc_isqrt.sv =====
// ibgc_isqrt: digit-by-digit floor square root, one root bit per cycle.
// Depends on ibgc_pkg.
module ibgc_isqrt import ibgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam logic [4:0] LastStep = 5'(RootW - 1);

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [RadW-1:0]  x_q;
  logic [RootW:0]   rem_q;
  logic [RootW-1:0] root_q;
  logic [RootW+2:0] rem_sh, trial, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, x_q[RadW-1:RadW-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[RootW:0] : rem_sh[RootW:0];
      root_q <= {root_q[RootW-2:0], ge};
      cnt_q  <= cnt_q + 5'd1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/ibgc_recip.sv =====
// ibgc_recip: saturating 2^(35+sel) / r restoring divider, one bit per cycle.
// A zero root yields all-ones quotient and so saturates. Depends on ibgc_pkg.
module ibgc_recip import ibgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       sel_i,
  input  logic [RootW-1:0] root_i,
  output logic             done_o,
  output logic [GainW-1:0] recip_o
);

  localparam logic [5:0] LastStep = 6'(RecipW - 1);

  logic              busy_q, done_q;
  logic [5:0]        cnt_q;
  logic [RecipW-1:0] quo_q;
  logic [RootW-1:0]  rem_q, dvs_q;
  logic [RootW:0]    rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[RecipW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= RecipW'(1) << (6'd35 + 6'(sel_i));
      rem_q  <= '0;
      dvs_q  <= root_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[RootW-1:0] : rem_sh[RootW-1:0];
      quo_q <= {quo_q[RecipW-2:0], ge};
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o  = done_q;
  assign recip_o = (quo_q[RecipW-1:GainW] != '0) ? GainMax : quo_q[GainW-1:0];

endmodule

// ===== rtl/imu_bias_gain_calibrator.sv =====
// imu_bias_gain_calibrator: static accel/gyro bias and gain calibration, top level.
// An ignored sample goes from S_CHECK to S_OUT, a rejected one through S_SQUARE and S_STILL;
// one that is averaged runs the 26-step mean-update lanes, the 25-step square root, the 39-step
// reciprocal and the 26-step gain update, via S_STILL after warm-up; S_OUT waits on a stalled output.
// One transaction at a time; the next is taken once the result is in the output register.
// Reset: config 1000/0/6554, means cleared, gain 1.0, status running.
module imu_bias_gain_calibrator import ibgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [23:0] accel_bias_x_o,
  output logic signed [23:0] accel_bias_y_o,
  output logic signed [23:0] accel_bias_z_o,
  output logic signed [23:0] gyro_bias_x_o,
  output logic signed [23:0] gyro_bias_y_o,
  output logic signed [23:0] gyro_bias_z_o,
  output logic [17:0]        gain_estimate_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQUARE, S_STILL, S_BIAS, S_DSQ, S_DSUM,
    S_SQRT, S_RECIP, S_GAIN, S_WRAP, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [14:0] sample_count_q;
  logic [1:0]  range_sel_q;
  logic [15:0] still_thr_q;

  // Calibration state
  logic [14:0]        index_q;
  logic [6:0]         restarts_q;
  status_e            progress_q;
  logic signed [23:0] acc_st_q [3];
  logic signed [23:0] gyr_st_q [3];
  logic [GainW-1:0]   gain_q;

  // Captured sample and intermediate values
  logic signed [15:0] a_q [3];
  logic signed [15:0] g_q [3];
  logic [31:0]        sq_q [3];
  logic [33:0]        hi2_q, lo2_q;
  logic [49:0]        dsq_q [3];

  // Output register
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic signed [23:0] o_acc_q [3];
  logic signed [23:0] o_gyr_q [3];
  logic [GainW-1:0]   o_gain_q;

  // Lane control
  logic             bias_start, gain_start, sqrt_start, recip_start;
  div_res_t         acc_res [3];
  div_res_t         gyr_res [3];
  div_res_t         gain_res;
  logic [DvsW-1:0]  divisor;
  logic             sqrt_done, recip_done;
  logic [RootW-1:0] root;
  logic [GainW-1:0] recip;

  assign divisor = {1'b0, index_q} + 16'd1;

  // Bias lanes: three accel, three gyro, all sharing the sample-index-plus-one divisor.
  logic [14:0]        onegee;
  logic signed [16:0] az_off;
  assign onegee = 15'd2048 << range_sel_q;
  assign az_off = {a_q[2][15], a_q[2]} - {2'b00, onegee};

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [DivW-1:0] acc_tgt, acc_dvd, gyr_dvd;
    assign acc_tgt = (k == 2) ? {az_off[16], az_off, 8'h00}
                              : {{2{a_q[k][15]}}, a_q[k], 8'h00};
    assign acc_dvd = acc_tgt - {{2{acc_st_q[k][23]}}, acc_st_q[k]};
    assign gyr_dvd = {{2{g_q[k][15]}}, g_q[k], 8'h00}
                   - {{2{gyr_st_q[k][23]}}, gyr_st_q[k]};

    ibgc_div_lane u_acc (
      .clk_i, .rst_ni, .start_i(bias_start),
      .dividend_i(acc_dvd), .divisor_i(divisor), .res_o(acc_res[k])
    );
    ibgc_div_lane u_gyr (
      .clk_i, .rst_ni, .start_i(bias_start),
      .dividend_i(gyr_dvd), .divisor_i(divisor), .res_o(gyr_res[k])
    );
  end

  // Merge stage: sum of squared residuals feeds the square root.
  logic [RadW-1:0] dsum;
  assign dsum = dsq_q[0] + dsq_q[1] + dsq_q[2];

  ibgc_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .radicand_i(dsum),
    .done_o(sqrt_done), .root_o(root)
  );

  ibgc_recip u_recip (
    .clk_i, .rst_ni, .start_i(recip_start), .sel_i(range_sel_q), .root_i(root),
    .done_o(recip_done), .recip_o(recip)
  );

  // Gain mean update uses another instance of the lane divider.
  logic signed [GainW:0]  gdiff;
  logic signed [DivW-1:0] gain_dvd;
  assign gdiff    = $signed({1'b0, recip}) - $signed({1'b0, gain_q});
  assign gain_dvd = {{(DivW-GainW-1){gdiff[GainW]}}, gdiff};

  ibgc_div_lane u_gain (
    .clk_i, .rst_ni, .start_i(gain_start),
    .dividend_i(gain_dvd), .divisor_i(divisor), .res_o(gain_res)
  );

  // Stillness test on the raw magnitude squared.
  logic [31:0] s_sum;
  logic [41:0] lhs;
  logic [3:0]  shamt;
  logic        moving;
  logic [6:0]  restarts_inc;
  assign s_sum  = sq_q[0] + sq_q[1] + sq_q[2];
  assign shamt  = 4'd10 - {1'b0, range_sel_q, 1'b0};
  assign lhs    = {10'b0, s_sum} << shamt;
  assign moving = (lhs > {8'b0, hi2_q}) || (lhs < {8'b0, lo2_q});
  assign restarts_inc = (restarts_q < RestartSat) ? restarts_q + 7'd1 : restarts_q;

  logic [16:0] hi, lo;
  assign hi = 17'd65536 + {1'b0, still_thr_q};
  assign lo = 17'd65536 - {1'b0, still_thr_q};

  logic [14:0] index_inc;
  assign index_inc = index_q + 15'd1;

  assign bias_start  = (state_q == S_CHECK && progress_q == ST_RUNNING
                        && index_q < sample_count_q && index_q <= WarmupSamples)
                    || (state_q == S_STILL && !moving);
  assign sqrt_start  = (state_q == S_DSUM);
  assign recip_start = (state_q == S_SQRT) && sqrt_done;
  assign gain_start  = (state_q == S_RECIP) && recip_done;

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 15'd1000;
      range_sel_q    <= 2'd0;
      still_thr_q    <= 16'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[14:0];
        CFG_ACCEL_RANGE:  range_sel_q    <= cfg_data_i[1:0];
        CFG_STILL_THR:    still_thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      index_q     <= '0;
      restarts_q  <= '0;
      progress_q  <= ST_RUNNING;
      gain_q      <= GainOne;
      out_valid_q <= 1'b0;
      status_q    <= ST_RUNNING;
      o_gain_q    <= GainOne;
      hi2_q       <= '0;
      lo2_q       <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_st_q[k] <= '0;
        gyr_st_q[k] <= '0;
        o_acc_q[k]  <= '0;
        o_gyr_q[k]  <= '0;
        a_q[k]      <= '0;
        g_q[k]      <= '0;
        sq_q[k]     <= '0;
        dsq_q[k]    <= '0;
      end
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            a_q[0] <= accel_x_i;
            a_q[1] <= accel_y_i;
            a_q[2] <= accel_z_i;
            g_q[0] <= gyro_x_i;
            g_q[1] <= gyro_y_i;
            g_q[2] <= gyro_z_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (progress_q != ST_RUNNING) begin
            state_q <= S_OUT;
          end else if (index_q >= sample_count_q) begin
            progress_q <= ST_DONE;
            state_q    <= S_OUT;
          end else if (index_q > WarmupSamples) begin
            state_q <= S_SQUARE;
          end else begin
            state_q <= S_BIAS;
          end
        end
        S_SQUARE: begin
          for (int k = 0; k < 3; k++) begin
            logic signed [31:0] aw;
            aw = 32'(a_q[k]);
            sq_q[k] <= 32'(aw * aw);
          end
          hi2_q   <= hi * hi;
          lo2_q   <= lo * lo;
          state_q <= S_STILL;
        end
        S_STILL: begin
          if (moving) begin
            restarts_q <= restarts_inc;
            if (restarts_inc > MaxRestarts) begin
              progress_q <= ST_FAILED;
            end else begin
              for (int k = 0; k < 3; k++) begin
                acc_st_q[k] <= '0;
                gyr_st_q[k] <= '0;
              end
              gain_q  <= GainOne;
              index_q <= '0;
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_BIAS;
          end
        end
        S_BIAS: begin
          if (acc_res[0].done) begin
            for (int k = 0; k < 3; k++) begin
              acc_st_q[k] <= sat24(27'(acc_st_q[k]) + 27'(acc_res[k].quotient));
              gyr_st_q[k] <= sat24(27'(gyr_st_q[k]) + 27'(gyr_res[k].quotient));
            end
            state_q <= S_DSQ;
          end
        end
        S_DSQ: begin
          // residual of the raw accel against the new means (Z keeps 1 g)
          for (int k = 0; k < 3; k++) begin
            logic signed [24:0] d;
            logic signed [49:0] dw;
            d  = {a_q[k][15], a_q[k], 8'h00} - {acc_st_q[k][23], acc_st_q[k]};
            dw = 50'(d);
            dsq_q[k] <= 50'(dw * dw);
          end
          state_q <= S_DSUM;
        end
        S_DSUM: state_q <= S_SQRT;
        S_SQRT: if (sqrt_done) state_q <= S_RECIP;
        S_RECIP: if (recip_done) state_q <= S_GAIN;
        S_GAIN: begin
          if (gain_res.done) begin
            gain_q  <= gain_q + gain_res.quotient[GainW-1:0];
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          index_q <= index_inc;
          if (index_inc >= sample_count_q) progress_q <= ST_DONE;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= progress_q;
            o_gain_q    <= gain_q;
            for (int k = 0; k < 3; k++) begin
              o_acc_q[k] <= acc_st_q[k];
              o_gyr_q[k] <= gyr_st_q[k];
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign accel_bias_x_o  = o_acc_q[0];
  assign accel_bias_y_o  = o_acc_q[1];
  assign accel_bias_z_o  = o_acc_q[2];
  assign gyro_bias_x_o   = o_gyr_q[0];
  assign gyro_bias_y_o   = o_gyr_q[1];
  assign gyro_bias_z_o   = o_gyr_q[2];
  assign gain_estimate_o = o_gain_q;

endmodule
